// ===== rtl/core/mbet_pkg.sv =====
// ----------------------------------------------------------------------------
// mbet_pkg
// Shared widths, fixed-point constants and control structs for the
// Mandelbrot escape-time block.
// ----------------------------------------------------------------------------
package mbet_pkg;

    localparam int COL_W    = 12;
    localparam int ROW_W    = 11;
    localparam int ITER_W   = 16;
    localparam int STEP_W   = 31;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = STEP_W;

    localparam int FRAC_W   = 28;                   // Q4.28
    localparam int Z_W      = 30;                   // |x|,|y| < 2 after a live iteration
    localparam int SQ_W     = 2 * Z_W;              // exact Q.56 products
    localparam int PRE_W    = COL_W + STEP_W;       // col * step, Q.30
    localparam int PIM_W    = ROW_W + STEP_W;       // row * step, Q.30
    localparam int C_W      = PRE_W - 1;            // signed Q.28 point, dropped 2 LSBs
    localparam int NEXT_W   = C_W + 1;              // new component before range test

    localparam logic [ITER_W-1:0] MAX_ITER_RST = ITER_W'(256);
    localparam logic [STEP_W-1:0] STEP_RST     = STEP_W'(4194304);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STEP = CFG_IDX_W'(1);

    typedef struct packed {
        logic load;     // capture col*step, row*step
        logic init;     // form c, clear z and iteration count
        logic mult;     // register x*x, y*y, x*y
        logic update;   // escape tests and z <= z*z + c
    } t_cmd;

    typedef struct packed {
        logic done;     // item finished on this update
    } t_status;

endpackage

// ===== rtl/core/mbet_ctrl.sv =====
// ----------------------------------------------------------------------------
// mbet_ctrl
// Sequencer: a setup state, then alternating multiply and update
// states until the datapath reports the pixel finished.
// ----------------------------------------------------------------------------
module mbet_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  mbet_pkg::t_status i_status,
    output mbet_pkg::t_cmd   o_cmd,
    output logic             o_result_valid
);
    import mbet_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INIT,
        S_MULT,
        S_UPDATE
    } t_state;

    t_state r_state, n_state;
    logic   r_result_valid, n_result_valid;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = (r_state == S_IDLE) && start;
        o_cmd.init   = (r_state == S_INIT);
        o_cmd.mult   = (r_state == S_MULT);
        o_cmd.update = (r_state == S_UPDATE);
    end

    always_comb begin
        n_state        = r_state;
        n_result_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                n_state = S_MULT;
            end
            S_MULT: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (i_status.done) begin
                    n_state        = S_IDLE;
                    n_result_valid = 1'b1;
                end else begin
                    n_state = S_MULT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_result_valid <= n_result_valid;
        end
    end

    assign o_result_valid = r_result_valid;

endmodule

// ===== rtl/core/mbet_datapath.sv =====
// ----------------------------------------------------------------------------
// mbet_datapath
// Fixed-point point setup, complex squaring and escape tests for one pixel.
// ----------------------------------------------------------------------------
module mbet_datapath (
    input  logic                          i_clk,
    input  mbet_pkg::t_cmd                i_cmd,
    output mbet_pkg::t_status             o_status,
    input  logic [mbet_pkg::COL_W-1:0]    i_pixel_col,
    input  logic [mbet_pkg::ROW_W-1:0]    i_pixel_row,
    input  logic [mbet_pkg::ITER_W-1:0]   i_max_iter,
    input  logic [mbet_pkg::STEP_W-1:0]   i_pixel_step,
    output logic [mbet_pkg::ITER_W-1:0]   o_escape_count
);
    import mbet_pkg::*;

    localparam logic signed [C_W-1:0]    TWO_C  = C_W'(64'sd1 <<< (FRAC_W + 1));
    localparam logic signed [C_W-1:0]    ONE_C  = C_W'(64'sd1 <<< FRAC_W);
    localparam logic signed [NEXT_W-1:0] LIM_HI = NEXT_W'(64'sd1 <<< (FRAC_W + 1));
    localparam logic signed [NEXT_W-1:0] LIM_LO = -LIM_HI;
    localparam logic [SQ_W:0]            FOUR_SQ = (SQ_W+1)'(64'd1 << (2 * FRAC_W + 2));

    logic [PRE_W-1:0]         r_prod_re;
    logic [PIM_W-1:0]         r_prod_im;
    logic signed [C_W-1:0]    r_cre, r_cim;
    logic signed [Z_W-1:0]    r_x, r_y;
    logic signed [SQ_W-1:0]   r_xx, r_yy, r_xy;
    logic [ITER_W-1:0]        r_iter;
    logic [ITER_W-1:0]        r_result;

    logic signed [SQ_W:0]     w_diff;
    logic [SQ_W:0]            w_mag;
    logic signed [NEXT_W-1:0] w_nx, w_ny;
    logic                     w_sq_esc, w_at_max, w_abs_esc;

    // z*z + c; floor shifts are arithmetic right shifts
    assign w_diff = {r_xx[SQ_W-1], r_xx} - {r_yy[SQ_W-1], r_yy};
    assign w_nx   = NEXT_W'($signed(w_diff[SQ_W:FRAC_W])) + NEXT_W'(r_cre);
    assign w_ny   = NEXT_W'($signed(r_xy[SQ_W-1:FRAC_W-1])) + NEXT_W'(r_cim);
    assign w_mag  = {1'b0, r_xx} + {1'b0, r_yy};

    // squares belong to the z reached at the current count
    assign w_sq_esc  = (w_mag >= FOUR_SQ);
    assign w_at_max  = (r_iter == i_max_iter);
    assign w_abs_esc = (w_nx >= LIM_HI) || (w_nx <= LIM_LO)
                    || (w_ny >= LIM_HI) || (w_ny <= LIM_LO);

    assign o_status.done = i_cmd.update && (w_sq_esc || w_at_max || w_abs_esc);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_prod_re <= PRE_W'(i_pixel_col) * PRE_W'(i_pixel_step);
            r_prod_im <= PIM_W'(i_pixel_row) * PIM_W'(i_pixel_step);
        end
        if (i_cmd.init) begin
            r_cre  <= $signed({1'b0, r_prod_re[PRE_W-1:2]}) - TWO_C;
            r_cim  <= $signed({2'b00, r_prod_im[PIM_W-1:2]}) - ONE_C;
            r_x    <= '0;
            r_y    <= '0;
            r_iter <= '0;
        end
        if (i_cmd.mult) begin
            r_xx <= SQ_W'(r_x) * SQ_W'(r_x);
            r_yy <= SQ_W'(r_y) * SQ_W'(r_y);
            r_xy <= SQ_W'(r_x) * SQ_W'(r_y);
        end
        if (i_cmd.update) begin
            r_x    <= w_nx[Z_W-1:0];
            r_y    <= w_ny[Z_W-1:0];
            r_iter <= r_iter + ITER_W'(1);
            if (w_sq_esc) begin
                r_result <= r_iter;
            end else if (w_at_max) begin
                r_result <= '0;
            end else begin
                r_result <= r_iter + ITER_W'(1);
            end
        end
    end

    assign o_escape_count = r_result;

endmodule

// ===== rtl/core/mandelbrot_escape_time.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time count for one pixel in signed Q4.28 fixed point.
// ----------------------------------------------------------------------------
// From the start transfer to the result strobe: a setup state, then N rounds,
//   where N (at most max_iterations + 1) is the number of squaring rounds; each
//   round is a multiply state and an update state. The strobe is registered.
// Throughput: one pixel at a time; a new start is taken in the strobe cycle.
// The receiver cannot stall; the strobe is high for exactly one cycle.
// Reset (sync, active low): idle, max_iterations = 256, pixel_step = 2^22.
module mandelbrot_escape_time (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [mbet_pkg::COL_W-1:0]        i_pixel_col,
    input  logic [mbet_pkg::ROW_W-1:0]        i_pixel_row,
    output logic                              o_result_valid,
    output logic [mbet_pkg::ITER_W-1:0]       o_escape_count,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mbet_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mbet_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import mbet_pkg::*;

    logic [ITER_W-1:0] r_max_iter;
    logic [STEP_W-1:0] r_pixel_step;
    t_cmd              w_cmd;
    t_status           w_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter   <= MAX_ITER_RST;
            r_pixel_step <= STEP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_MAX_ITER) begin
                r_max_iter <= i_cfg_data[ITER_W-1:0];
            end else if (i_cfg_index == REG_PIXEL_STEP) begin
                r_pixel_step <= i_cfg_data[STEP_W-1:0];
            end
        end
    end

    mbet_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_status       (w_status),
        .o_cmd          (w_cmd),
        .o_result_valid (o_result_valid)
    );

    mbet_datapath u_datapath (
        .i_clk          (i_clk),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_pixel_col    (i_pixel_col),
        .i_pixel_row    (i_pixel_row),
        .i_max_iter     (r_max_iter),
        .i_pixel_step   (r_pixel_step),
        .o_escape_count (o_escape_count)
    );

    // a result only ends an item, so the block is idle while it is shown
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobe while busy");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_result_valid))
        else $error("accepted start did not enter busy");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("back-to-back result strobes");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_escape_count <= r_max_iter))
        else $error("escape count above iteration limit");

endmodule

// ===== tb/mbet_checker.sv =====
// ----------------------------------------------------------------------------
// mbet_checker
// Watches the pixel, result and register channels of the escape-time block.
// It keeps its own copy of the two registers and works out the escape count
// of every accepted pixel in Q4.28 fixed point. Each result strobe is compared
// with the oldest count still owed.
// ----------------------------------------------------------------------------
module mbet_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            i_busy,
    input  logic [mbet_pkg::COL_W-1:0]      i_pixel_col,
    input  logic [mbet_pkg::ROW_W-1:0]      i_pixel_row,
    input  logic                            i_result_valid,
    input  logic [mbet_pkg::ITER_W-1:0]     i_escape_count,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [mbet_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mbet_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_pending,
    output int                              o_error_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import mbet_pkg::*;

    localparam longint TWO_Q28  = 64'sd1 <<< (FRAC_W + 1);
    localparam longint ONE_Q28  = 64'sd1 <<< FRAC_W;
    localparam longint FOUR_Q56 = 64'sd1 <<< (2 * FRAC_W + 2);

    typedef struct {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [ITER_W-1:0] count;
    } t_owed_count;

    logic [ITER_W-1:0] iter_limit = MAX_ITER_RST;
    logic [STEP_W-1:0] step_q30   = STEP_RST;
    t_owed_count       owed_counts[$];
    int                pending    = 0;
    int                mismatches = 0;

    assign o_pending     = pending;
    assign o_error_count = mismatches;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // escape-time iteration, floor on every rescale
    function automatic logic [ITER_W-1:0] escape_count_of(
        input logic [COL_W-1:0] col,
        input logic [ROW_W-1:0] row
    );
        longint      c_re, c_im, x, y, nx, ny, xx, yy, xy;
        int unsigned n;
        logic [ITER_W-1:0] found;
        c_re  = longint'((64'(col) * 64'(step_q30)) >> 2) - TWO_Q28;
        c_im  = longint'((64'(row) * 64'(step_q30)) >> 2) - ONE_Q28;
        x     = 0;
        y     = 0;
        found = '0;
        for (n = 1; n <= 32'(iter_limit); n++) begin
            xx = x * x;
            yy = y * y;
            xy = x * y;
            nx = ((xx - yy) >>> FRAC_W) + c_re;
            ny = ((2 * xy) >>> FRAC_W) + c_im;
            x  = nx;
            y  = ny;
            // a component of magnitude two or more escapes without squaring
            if (x >= TWO_Q28 || x <= -TWO_Q28 || y >= TWO_Q28 || y <= -TWO_Q28) begin
                found = ITER_W'(n);
                break;
            end
            if (x * x + y * y >= FOUR_Q56) begin
                found = ITER_W'(n);
                break;
            end
        end
        return found;
    endfunction

    always @(posedge i_clk) begin
        t_owed_count head, item;
        if (!i_rst_n) begin
            iter_limit = MAX_ITER_RST;
            step_q30   = STEP_RST;
            owed_counts.delete();
        end else begin
            // a result may come in the same cycle as the next start transfer
            if (i_result_valid === 1'b1) begin
                if (owed_counts.size() == 0) begin
                    report_mismatch($sformatf("escape count %0d with no pixel owed",
                                              i_escape_count));
                end else begin
                    head = owed_counts.pop_front();
                    if (i_escape_count !== head.count)
                        report_mismatch($sformatf(
                            "pixel (%0d,%0d): escape count %0d, want %0d",
                            head.col, head.row, i_escape_count, head.count));
                end
            end
            if (i_cfg_valid === 1'b1 && i_cfg_ready === 1'b1) begin
                case (i_cfg_index)
                    REG_MAX_ITER:   iter_limit = i_cfg_data[ITER_W-1:0];
                    REG_PIXEL_STEP: step_q30   = i_cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                item.col   = i_pixel_col;
                item.row   = i_pixel_row;
                item.count = escape_count_of(i_pixel_col, i_pixel_row);
                owed_counts.push_back(item);
            end
        end
        pending = owed_counts.size();
    end

endmodule

// ===== tb/tb_mandelbrot_escape_time.sv =====
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_time
// Drives pixels and register writes into the escape-time block: a directed
// set of points inside, outside and on the edge of the set under extreme register
// values, then random phases with random limits and steps. Gaps on both request
// channels are random, bar one phase's pixels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_time;
    timeunit 1ns;
    timeprecision 1ps;

    import mbet_pkg::*;

    localparam int                 STALL_LIMIT      = 400000;
    localparam int                 PHASES           = 12;
    localparam int                 PIXELS_PER_PHASE = 119;
    localparam logic [STEP_W-1:0]  ONE_STEP         = STEP_W'(1 << 30);
    localparam logic [STEP_W-1:0]  STEP_MAX         = {STEP_W{1'b1}};
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED   = CFG_IDX_W'(2);

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [COL_W-1:0]      pixel_col;
    logic [ROW_W-1:0]      pixel_row;
    logic                  o_result_valid;
    logic [ITER_W-1:0]     o_escape_count;
    logic                  cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int     pending_count;
    int     error_count;
    bit     gaps_on = 1'b1;
    longint cur_step;

    always #10 i_clk = ~i_clk;

    mandelbrot_escape_time DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_pixel_col    (pixel_col),
        .i_pixel_row    (pixel_row),
        .o_result_valid (o_result_valid),
        .o_escape_count (o_escape_count),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    mbet_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_pixel_col    (pixel_col),
        .i_pixel_row    (pixel_row),
        .i_result_valid (o_result_valid),
        .i_escape_count (o_escape_count),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_pending      (pending_count),
        .o_error_count  (error_count)
    );

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_pixel(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
        while (gaps_on && $urandom_range(99) < 36) begin
            start     <= 1'b0;
            pixel_col <= COL_W'($urandom);
            pixel_row <= ROW_W'($urandom);
            @(negedge i_clk);
        end
        start     <= 1'b1;
        pixel_col <= col;
        pixel_row <= row;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        while (gaps_on && $urandom_range(99) < 36) begin
            cfg_valid <= 1'b0;
            @(negedge i_clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // registers change only with no pixel in flight
    task automatic configure(input logic [ITER_W-1:0] iters,
                             input logic [STEP_W-1:0] step,
                             input logic [CFG_DATA_W-ITER_W-1:0] upper_junk);
        start <= 1'b0;
        while (pending_count != 0 || busy) @(negedge i_clk);
        write_reg(REG_MAX_ITER, {upper_junk, iters});
        write_reg(REG_PIXEL_STEP, step);
        // unmapped indexes must leave both registers alone
        write_reg(REG_UNMAPPED | CFG_IDX_W'($urandom_range(1)), CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
        cur_step = step;
    endtask

    task automatic random_phase(input bit gaps);
        int                r;
        logic [ITER_W-1:0] iters;
        logic [STEP_W-1:0] step;
        longint            col_hi, row_hi;
        r = $urandom_range(99);
        if (r < 10)      iters = ITER_W'(1);
        else if (r < 60) iters = ITER_W'($urandom_range(40, 2));
        else if (r < 90) iters = ITER_W'($urandom_range(128, 41));
        else             iters = ITER_W'($urandom_range(300, 129));
        r = $urandom_range(99);
        if (r < 10)      step = STEP_W'($urandom_range(1000, 1));
        else if (r < 20) step = STEP_W'($urandom);
        else if (r < 30) step = ONE_STEP;
        else             step = ONE_STEP / STEP_W'($urandom_range(4096, 1));
        configure(iters, step, (CFG_DATA_W - ITER_W)'($urandom));
        // window around the set: re in [-2, 0.5], im in [-1, 1]
        col_hi = (cur_step == 0) ? 4095 : (longint'(5) << 29) / cur_step;
        row_hi = (cur_step == 0) ? 2047 : (longint'(1) << 31) / cur_step;
        if (col_hi > 4095) col_hi = 4095;
        if (row_hi > 2047) row_hi = 2047;
        gaps_on = gaps;
        repeat (PIXELS_PER_PHASE) begin
            if ($urandom_range(99) < 70)
                send_pixel(COL_W'($urandom_range(int'(col_hi))),
                           ROW_W'($urandom_range(int'(row_hi))));
            else
                send_pixel(COL_W'($urandom), ROW_W'($urandom));
        end
        gaps_on = 1'b1;
    endtask

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (i_rst_n !== 1'b1 || (start && !busy) || o_result_valid
                || (cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_mandelbrot_escape_time: done, errors");
        $finish;
    end

    initial begin
        i_rst_n   = 1'b0;
        start     = 1'b0;
        pixel_col = '0;
        pixel_row = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        cur_step  = STEP_RST;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset registers: 256 iterations, resolution 256
        send_pixel(512, 256);      // c = 0, inside
        send_pixel(0, 0);          // c = -2 - i, out at once
        send_pixel(4095, 2047);
        send_pixel(0, 256);        // c = -2, component hits two exactly
        send_pixel(1, 256);        // just right of -2 on the real axis
        send_pixel(576, 256);      // c = 0.25, cusp
        send_pixel(577, 256);      // just past the cusp, slow escape
        send_pixel(256, 256);      // c = -1, period two
        send_pixel(704, 256);
        send_pixel(512, 512);      // c = i
        send_pixel(512, 0);        // c = -i
        send_pixel(4095, 0);
        send_pixel(384, 440);

        // no iterations at all, then zero step
        configure(0, 0, '1);
        send_pixel(0, 0);
        send_pixel(4095, 2047);
        configure(256, 0, '0);
        send_pixel(4095, 2047);
        send_pixel(1234, 777);

        // widest step: c far outside Q4.28
        configure(1, STEP_MAX, '1);
        send_pixel(4095, 2047);
        send_pixel(1, 1);
        send_pixel(0, 0);

        // largest limit at resolution one
        configure('1, ONE_STEP, '0);
        send_pixel(2, 1);          // c = 0, runs the full limit
        send_pixel(3, 2);
        send_pixel(4095, 2047);

        for (int p = 0; p < PHASES; p++)
            random_phase(p != 3);

        start <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (1000) @(negedge i_clk);

        if (error_count == 0)
            $display("tb_mandelbrot_escape_time: done, clean");
        else
            $display("tb_mandelbrot_escape_time: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/mbet_pkg.sv
rtl/core/mbet_ctrl.sv
rtl/core/mbet_datapath.sv
rtl/core/mandelbrot_escape_time.sv
tb/mbet_checker.sv
tb/tb_mandelbrot_escape_time.sv
